### rtl/core/sfla_pkg.sv
package sfla_pkg;

  localparam int unsigned MAX_DIMENSION_DEF = 8192;
  localparam int unsigned GRID_CELLS_DEF    = 64;

  localparam int unsigned CFG_DIM_W    = 14;
  localparam int unsigned CFG_THRESH_W = 18;
  localparam int unsigned CFG_DATA_W   = 18;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned COEF_W   = 10;
  localparam int unsigned LUMA_W   = 18;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned COUNT_W  = 15;
  localparam int unsigned REM_W    = 16;
  localparam int unsigned ALU_W    = 33;
  localparam int unsigned DCNT_W   = 5;

  localparam logic [COEF_W-1:0]  COEF_R      = 10'd299;
  localparam logic [COEF_W-1:0]  COEF_G      = 10'd587;
  localparam logic [COEF_W-1:0]  COEF_B      = 10'd114;
  localparam logic [LUMA_W-1:0]  LUMA_FULL   = 18'd255000;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 15'd32767;

  localparam logic [CFG_DIM_W-1:0]    WIDTH_RST  = 14'd1920;
  localparam logic [CFG_DIM_W-1:0]    HEIGHT_RST = 14'd1080;
  localparam logic [CFG_THRESH_W-1:0] THRESH_RST = 18'd0;

  typedef enum logic [1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_ORDER,
    CFG_THRESH
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MAC
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_MUL_G,
    ST_MUL_B,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic sample;
    logic frame_end;
  } grid_stat_t;

endpackage

### rtl/core/sfla_pix_if.sv
interface sfla_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;

  modport source (output valid, first_byte, second_byte, third_byte, input ready);
  modport sink   (input valid, first_byte, second_byte, third_byte, output ready);
endinterface

### rtl/core/sfla_res_if.sv
interface sfla_res_if;
  logic        valid;
  logic        ready;
  logic [17:0] mean_luma;
  logic [14:0] sample_total;
  logic        bright_enough;

  modport source (output valid, mean_luma, sample_total, bright_enough, input ready);
  modport sink   (input valid, mean_luma, sample_total, bright_enough, output ready);
endinterface

### rtl/core/sfla_alu.sv
module sfla_alu (
  input  sfla_pkg::alu_op_t op,
  input  logic [32:0]       a,
  input  logic [32:0]       b,
  input  logic [9:0]        coef,
  input  logic [7:0]        pix,
  output logic [33:0]       res
);
  import sfla_pkg::*;

  logic [LUMA_W-1:0] prod;

  assign prod = LUMA_W'(coef) * LUMA_W'(pix);

  always_comb begin
    case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} + {1'b0, ~b} + 34'd1;
      ALU_MAC: res = {1'b0, a} + 34'(prod);
      default: res = '0;
    endcase
  end

endmodule

### rtl/core/sfla_grid.sv
module sfla_grid #(
  parameter int unsigned MAX_DIMENSION = sfla_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned GRID_CELLS    = sfla_pkg::GRID_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic [13:0]          cfg_width,
  input  logic [13:0]          cfg_height,
  output sfla_pkg::grid_stat_t stat
);
  import sfla_pkg::*;

  localparam int unsigned POS_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CMP_W = DIM_W + 1;
  localparam int unsigned MW    = $clog2(MAX_DIMENSION + 2 * GRID_CELLS + 1);
  localparam logic [15:0]    MAX_D     = 16'(MAX_DIMENSION);
  localparam logic [MW-1:0]  MARK_BASE = MW'(2 * GRID_CELLS);
  localparam logic [MW-1:0]  MARK_STEP = MW'(GRID_CELLS);

  // marks hold (phase + 2) * GRID_CELLS; a phase wraps once the dimension is below its mark
  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [MW-1:0]    col_mark_r, col_mark_nxt, row_mark_r, row_mark_nxt;
  logic [15:0]      w16, h16;
  logic [DIM_W-1:0] w, h;
  logic             row_end, frame_end, col_wrap, row_wrap;

  always_comb begin
    w16 = {2'b0, cfg_width};
    h16 = {2'b0, cfg_height};
    if (w16 == 16'd0) w16 = 16'd1;
    else if (w16 > MAX_D) w16 = MAX_D;
    if (h16 == 16'd0) h16 = 16'd1;
    else if (h16 > MAX_D) h16 = MAX_D;
  end

  assign w = w16[DIM_W-1:0];
  assign h = h16[DIM_W-1:0];

  assign row_end   = (CMP_W'(col_r) + CMP_W'(1)) >= CMP_W'(w);
  assign frame_end = row_end && ((CMP_W'(row_r) + CMP_W'(1)) >= CMP_W'(h));
  assign col_wrap  = MW'(w) < col_mark_r;
  assign row_wrap  = MW'(h) < row_mark_r;

  assign stat.sample    = (col_mark_r == MARK_BASE) && (row_mark_r == MARK_BASE);
  assign stat.frame_end = frame_end;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    col_mark_nxt = col_mark_r;
    row_mark_nxt = row_mark_r;
    if (advance) begin
      if (frame_end) begin
        col_nxt      = '0;
        row_nxt      = '0;
        col_mark_nxt = MARK_BASE;
        row_mark_nxt = MARK_BASE;
      end else if (row_end) begin
        col_nxt      = '0;
        col_mark_nxt = MARK_BASE;
        row_nxt      = row_r + POS_W'(1);
        row_mark_nxt = row_wrap ? MARK_BASE : row_mark_r + MARK_STEP;
      end else begin
        col_nxt      = col_r + POS_W'(1);
        col_mark_nxt = col_wrap ? MARK_BASE : col_mark_r + MARK_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      col_mark_r <= MARK_BASE;
      row_mark_r <= MARK_BASE;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      col_mark_r <= col_mark_nxt;
      row_mark_r <= row_mark_nxt;
    end
  end

endmodule

### rtl/core/subsampled_frame_luma_average.sv
// Sub-sampled frame luma average. Pixels arrive in raster order; pixels on the
// max(1, dimension/GRID_CELLS) grid add their Rec.601 luma (thousandths of 8-bit
// units) to a 32-bit saturating sum. One shared multiply/add/subtract unit does
// the luma, sum and divide arithmetic; a grid pixel holds the input not ready
// through three multiply-accumulate passes and one accumulate, while a pixel off
// the grid, other than a frame's last, does not stall it. The last pixel of a
// frame adds a 32-step restoring division on the same unit, after which the mean,
// sample count and bright flag sit in an output register while the next frame is accepted.
module subsampled_frame_luma_average #(
  parameter int unsigned MAX_DIMENSION = sfla_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned GRID_CELLS    = sfla_pkg::GRID_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  sfla_pix_if.sink           in_pix,
  sfla_res_if.source         out_res,
  input  logic               cfg_we,
  input  sfla_pkg::cfg_idx_t cfg_index,
  input  logic [17:0]        cfg_data
);
  import sfla_pkg::*;

  state_t              state_r, state_nxt;
  grid_stat_t          gstat;
  logic                accept;

  logic [CFG_DIM_W-1:0]    width_r, height_r;
  logic                    red_first_r;
  logic [CFG_THRESH_W-1:0] thresh_r;

  logic [PIX_W-1:0]   r_r, g_r, b_r;
  logic               frame_end_r, frame_end_nxt;
  logic [LUMA_W-1:0]  luma_r, luma_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]   q_r, q_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt, trial;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LUMA_W-1:0]  mean_r, mean_nxt, mean_sel;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               bright_r, bright_nxt;

  alu_op_t            alu_op;
  logic [ALU_W-1:0]   alu_a, alu_b;
  logic [COEF_W-1:0]  alu_coef;
  logic [PIX_W-1:0]   alu_pix;
  logic [ALU_W:0]     alu_res;

  assign in_pix.ready = (state_r == ST_IDLE);
  assign accept       = in_pix.valid && in_pix.ready;

  assign out_res.valid         = out_valid_r;
  assign out_res.mean_luma     = mean_r;
  assign out_res.sample_total  = total_r;
  assign out_res.bright_enough = bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      red_first_r <= 1'b0;
      thresh_r    <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r     <= cfg_data[CFG_DIM_W-1:0];
        CFG_HEIGHT: height_r    <= cfg_data[CFG_DIM_W-1:0];
        CFG_ORDER:  red_first_r <= cfg_data[0];
        CFG_THRESH: thresh_r    <= cfg_data[CFG_THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  sfla_grid #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .GRID_CELLS    (GRID_CELLS)
  ) u_grid (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (accept),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .stat       (gstat)
  );

  sfla_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .coef (alu_coef),
    .pix  (alu_pix),
    .res  (alu_res)
  );

  assign trial = {rem_r[REM_W-2:0], q_r[SUM_W-1]};

  always_comb begin
    if (count_r == '0) mean_sel = '0;
    else if (q_r > SUM_W'(LUMA_FULL)) mean_sel = LUMA_FULL;
    else mean_sel = q_r[LUMA_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    frame_end_nxt = frame_end_r;
    luma_nxt      = luma_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    mean_nxt      = mean_r;
    total_nxt     = total_r;
    bright_nxt    = bright_r;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    alu_coef      = '0;
    alu_pix       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          frame_end_nxt = gstat.frame_end;
          if (gstat.sample) state_nxt = ST_MUL_R;
          else if (gstat.frame_end) state_nxt = ST_LOAD;
        end
      end
      ST_MUL_R: begin
        alu_op    = ALU_MAC;
        alu_coef  = COEF_R;
        alu_pix   = r_r;
        luma_nxt  = alu_res[LUMA_W-1:0];
        state_nxt = ST_MUL_G;
      end
      ST_MUL_G: begin
        alu_op    = ALU_MAC;
        alu_a     = ALU_W'(luma_r);
        alu_coef  = COEF_G;
        alu_pix   = g_r;
        luma_nxt  = alu_res[LUMA_W-1:0];
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        alu_op    = ALU_MAC;
        alu_a     = ALU_W'(luma_r);
        alu_coef  = COEF_B;
        alu_pix   = b_r;
        luma_nxt  = alu_res[LUMA_W-1:0];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        alu_op  = ALU_ADD;
        alu_a   = ALU_W'(sum_r);
        alu_b   = ALU_W'(luma_r);
        sum_nxt = alu_res[SUM_W] ? '1 : alu_res[SUM_W-1:0];
        if (count_r != COUNT_LIMIT) count_nxt = count_r + COUNT_W'(1);
        state_nxt = frame_end_r ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        q_nxt     = sum_r;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        alu_op   = ALU_SUB;
        alu_a    = ALU_W'(trial);
        alu_b    = ALU_W'(count_r);
        rem_nxt  = alu_res[ALU_W] ? alu_res[REM_W-1:0] : trial;
        q_nxt    = {q_r[SUM_W-2:0], alu_res[ALU_W]};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == '1) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          mean_nxt      = mean_sel;
          total_nxt     = count_r;
          bright_nxt    = mean_sel >= thresh_r;
          sum_nxt       = '0;
          count_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_end_r <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_end_r <= frame_end_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_r <= red_first_r ? in_pix.first_byte : in_pix.third_byte;
      g_r <= in_pix.second_byte;
      b_r <= red_first_r ? in_pix.third_byte : in_pix.first_byte;
    end
    luma_r  <= luma_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    mean_r  <= mean_nxt;
    total_r <= total_nxt;
    bright_r <= bright_nxt;
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside of completion");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (count_r != '0))
    else $error("frame closed with no samples");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && dcnt_r != '1) |=> (state_r == ST_DIV))
    else $error("divider left early");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (mean_r <= LUMA_FULL))
    else $error("mean above full scale");

endmodule

### verif/luma_frame_checker.sv
`timescale 1ns / 100ps
module luma_frame_checker (
  input  logic               clk,
  input  logic               rst_n,
  sfla_pix_if                pix,
  sfla_res_if                res,
  input  logic               cfg_we,
  input  sfla_pkg::cfg_idx_t cfg_index,
  input  logic [17:0]        cfg_data,
  output int unsigned        mismatch_count,
  output int unsigned        pending_frames,
  output int unsigned        frames_checked,
  output int unsigned        bright_frames
);
  import sfla_pkg::*;

  localparam int unsigned WEIGHT_R     = 299;
  localparam int unsigned WEIGHT_G     = 587;
  localparam int unsigned WEIGHT_B     = 114;
  localparam int unsigned FULL_SCALE   = 255000;
  localparam int unsigned SAMPLE_CAP   = 32767;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [17:0] mean_luma;
    logic [14:0] sample_total;
    logic        bright_enough;
  } frame_stat_t;

  logic [13:0] width_reg;
  logic [13:0] height_reg;
  logic        order_rgb;
  logic [17:0] thresh_reg;

  logic [12:0] col_pos;
  logic [12:0] row_pos;
  logic [6:0]  col_ph;
  logic [6:0]  row_ph;
  logic [31:0] luma_acc;
  logic [14:0] sample_cnt;

  frame_stat_t stat_q [$];

  function automatic int unsigned span(input logic [13:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return d;
  endfunction

  function automatic int unsigned grid_pitch(input int unsigned d);
    int unsigned s;
    s = d / GRID_CELLS_DEF;
    return (s == 0) ? 1 : s;
  endfunction

  function automatic void clear_frame();
    col_pos    = '0;
    row_pos    = '0;
    col_ph     = '0;
    row_ph     = '0;
    luma_acc   = '0;
    sample_cnt = '0;
  endfunction

  // one pixel beat; done is set on the last pixel of a frame
  function automatic void take_pixel(input logic [7:0] b0, input logic [7:0] g,
                                     input logic [7:0] b2, output bit done,
                                     output frame_stat_t stat);
    int unsigned w, h, sx, sy, red, blue, luma, mean;
    logic [32:0] acc;
    bit          row_end;
    w    = span(width_reg);
    h    = span(height_reg);
    sx   = grid_pitch(w);
    sy   = grid_pitch(h);
    red  = order_rgb ? b0 : b2;
    blue = order_rgb ? b2 : b0;
    stat = '0;
    done = 1'b0;
    if (col_ph == 0 && row_ph == 0) begin
      luma     = WEIGHT_R * red + WEIGHT_G * g + WEIGHT_B * blue;
      acc      = {1'b0, luma_acc} + 33'(luma);
      luma_acc = acc[32] ? '1 : acc[31:0];
      if (sample_cnt < SAMPLE_CAP) sample_cnt = sample_cnt + 1'b1;
    end
    row_end = col_pos >= w - 1;
    if (row_end && row_pos >= h - 1) begin
      mean = (sample_cnt != 0) ? luma_acc / sample_cnt : 0;
      if (mean > FULL_SCALE) mean = FULL_SCALE;
      stat.mean_luma     = mean[17:0];
      stat.sample_total  = sample_cnt;
      stat.bright_enough = mean >= thresh_reg;
      done = 1'b1;
      clear_frame();
    end else if (row_end) begin
      col_pos = '0;
      col_ph  = '0;
      row_pos = row_pos + 1'b1;
      row_ph  = (row_ph + 1 >= sy) ? '0 : row_ph + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
      col_ph  = (col_ph + 1 >= sx) ? '0 : col_ph + 1'b1;
    end
  endfunction

  always @(posedge clk) begin : monitor
    frame_stat_t want;
    frame_stat_t got;
    bit          done;
    if (!rst_n) begin
      width_reg  = 14'd1920;
      height_reg = 14'd1080;
      order_rgb  = 1'b0;
      thresh_reg = '0;
      clear_frame();
      stat_q.delete();
      mismatch_count = 0;
      frames_checked = 0;
      bright_frames  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg  = cfg_data[13:0];
          CFG_HEIGHT: height_reg = cfg_data[13:0];
          CFG_ORDER:  order_rgb  = cfg_data[0];
          CFG_THRESH: thresh_reg = cfg_data;
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        take_pixel(pix.first_byte, pix.second_byte, pix.third_byte, done, want);
        if (done) stat_q = {stat_q, want};
      end
      if (res.valid && res.ready) begin
        got = {res.mean_luma, res.sample_total, res.bright_enough};
        frames_checked++;
        if (got.bright_enough) bright_frames++;
        if (stat_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"mismatch: result beat %0d with no frame pending: ",
                      "mean %0d count %0d bright %0b"},
                     frames_checked, got.mean_luma, got.sample_total, got.bright_enough);
        end else begin
          want = stat_q.pop_front();
          if (got.mean_luma !== want.mean_luma || got.sample_total !== want.sample_total ||
              got.bright_enough !== want.bright_enough) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"mismatch: result beat %0d expected mean %0d count %0d bright %0b, ",
                        "got mean %0d count %0d bright %0b"}, frames_checked,
                       want.mean_luma, want.sample_total, want.bright_enough,
                       got.mean_luma, got.sample_total, got.bright_enough);
          end
        end
      end
    end
    pending_frames = stat_q.size();
  end

endmodule

### verif/subsampled_frame_luma_average_tb.sv
`timescale 1ns / 100ps
module subsampled_frame_luma_average_tb;
  import sfla_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 1300;
  localparam int unsigned PHASE_PIXELS  = 120;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT   = 500_000;

  typedef enum logic [1:0] {PACE_FREE, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREME} fill_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [17:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned pending_frames;
  int unsigned frames_checked;
  int unsigned bright_frames;

  int unsigned src_idle_pct    = 0;
  int unsigned snk_stall_pct   = 0;
  int unsigned frame_size      = 1;
  int unsigned pixels_sent     = 0;
  int unsigned configs_written = 0;
  int unsigned cycle_count     = 0;

  sfla_pix_if pix_bus();
  sfla_res_if res_bus();

  subsampled_frame_luma_average i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_bus),
    .out_res   (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  luma_frame_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix            (pix_bus),
    .res            (res_bus),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_frames (pending_frames),
    .frames_checked (frames_checked),
    .bright_frames  (bright_frames)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned span(input logic [13:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return d;
  endfunction

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_SRC_IDLE:  begin src_idle_pct = 71; snk_stall_pct = 0;  end
      PACE_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 71; end
      PACE_BOTH:      begin src_idle_pct = 8;  snk_stall_pct = 8;  end
      default:        begin src_idle_pct = 0;  snk_stall_pct = 0;  end
    endcase
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [17:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [17:0] w, input logic [17:0] h,
                           input logic order, input logic [17:0] thr);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_ORDER, {17'd0, order});
    write_reg(CFG_THRESH, thr);
    cfg_we <= 1'b0;
    frame_size = span(w[13:0]) * span(h[13:0]);
    configs_written++;
  endtask

  task automatic send_pixel(input logic [7:0] b0, input logic [7:0] g, input logic [7:0] b2);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.first_byte  <= b0;
    pix_bus.second_byte <= g;
    pix_bus.third_byte  <= b2;
    do @(posedge clk); while (!pix_bus.ready);
    pixels_sent++;
  endtask

  task automatic send_frame(input fill_t fill);
    logic [7:0] px [3];
    repeat (frame_size) begin
      for (int k = 0; k < 3; k++) begin
        case (fill)
          FILL_WHITE:   px[k] = 8'hFF;
          FILL_BLACK:   px[k] = 8'h00;
          FILL_EXTREME: px[k] = $urandom_range(1) ? 8'hFF : 8'h00;
          default:      px[k] = 8'($urandom_range(255));
        endcase
      end
      send_pixel(px[0], px[1], px[2]);
    end
  endtask

  // stop sending, let every pending frame result drain, then settle
  task automatic drain();
    pix_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_frames != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [17:0] w_val;
    logic [17:0] h_val;
    logic [17:0] thr_val;
    int unsigned random_start;
    int unsigned phase_start;
    int unsigned shape;
    fill_t       fill;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_WIDTH;
    cfg_data            <= '0;
    pix_bus.valid       <= 1'b0;
    pix_bus.first_byte  <= '0;
    pix_bus.second_byte <= '0;
    pix_bus.third_byte  <= '0;
    set_pace(PACE_FREE);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-pixel frames: primaries, black, white, RGB order
    configure(18'd1, 18'd1, 1'b1, 18'd0);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    drain();

    // BGR order, threshold at full scale
    configure(18'd1, 18'd1, 1'b0, 18'd255000);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFE, 8'hFF, 8'hFF);
    drain();

    // zero dimensions act as one; threshold above full scale never flags
    configure(18'd0, 18'd0, 1'b1, 18'h3FFFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    drain();

    set_pace(PACE_BOTH);
    configure(18'd3, 18'd2, 1'b0, 18'd128000);
    send_frame(FILL_RANDOM);
    drain();
    configure(18'd2, 18'd3, 1'b1, 18'd1);
    send_frame(FILL_EXTREME);
    drain();

    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      set_pace(pace_t'(configs_written[1:0]));
      shape = $urandom_range(99);
      if (shape < 70) begin
        w_val = 18'($urandom_range(8));
        h_val = 18'($urandom_range(6));
      end else if (shape < 85) begin
        w_val = 18'($urandom_range(300, 128));
        h_val = 18'($urandom_range(2, 1));
      end else begin
        w_val = 18'($urandom_range(2, 1));
        h_val = 18'($urandom_range(300, 128));
      end
      case ($urandom_range(4))
        0:       thr_val = '0;
        1:       thr_val = 18'($urandom_range(262143, 255001));
        default: thr_val = 18'($urandom_range(255000));
      endcase
      configure(w_val, h_val, 1'($urandom_range(1)), thr_val);
      phase_start = pixels_sent;
      do begin
        case ($urandom_range(9))
          0:       fill = FILL_WHITE;
          1:       fill = FILL_BLACK;
          2, 3:    fill = FILL_EXTREME;
          default: fill = FILL_RANDOM;
        endcase
        send_frame(fill);
        if ($urandom_range(9) == 0) drain();
      end while (pixels_sent - phase_start < PHASE_PIXELS);
      drain();
    end

    drain();
    $display("Run summary: %0d pixel beats over %0d register settings, %0d frames checked, %0d bright.",
             pixels_sent, configs_written, frames_checked, bright_frames);
    $display("Frames from 1x1 up to 300-pixel rows and columns, both byte orders, all thresholds.");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sfla_pkg.sv
rtl/core/sfla_pix_if.sv
rtl/core/sfla_res_if.sv
rtl/core/sfla_alu.sv
rtl/core/sfla_grid.sv
rtl/core/subsampled_frame_luma_average.sv
verif/luma_frame_checker.sv
verif/subsampled_frame_luma_average_tb.sv
